/* rtl/core/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is held.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked while reset is held.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/mcrm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mcrm_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CH_OUT_W     = 3;
    localparam int DATA_W       = 32;
    localparam int K_W          = 16;
    localparam int DIV_STEPS    = DATA_W;
    localparam int CNT_W        = $clog2(DIV_STEPS + 1);
    localparam int ADDR_W       = 2;

    localparam logic [CH_W-1:0]   LAST_CH       = CH_W'(NUM_CHANNELS - 1);
    localparam logic [CH_OUT_W-1:0] LAST_CH_TAG = CH_OUT_W'(NUM_CHANNELS - 1);
    localparam logic [K_W-1:0]    WINDOW_RESET  = 16'd64;
    localparam logic [ADDR_W-1:0] REG_WINDOW_LEN = 2'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic load;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/core/multichannel_running_mean.sv */
// Multichannel running mean of frequency and amplitude samples.
// The input stream carries one transaction per channel in round-robin order,
// starting at channel 0; s_tdata holds the frequency and amplitude in Q16.16.
// Each transaction yields one result transaction on the output stream with the
// channel's new averages, the channel index on m_tuser and m_tlast set for the
// last channel of a frame. During the first frame the averages stay as stored.
// The APB port holds the window length (address 0), which caps the divisor.
// After an input transaction is accepted, the radix-2 serial divider computes
// one quotient bit per cycle over 32 bits, then the result is committed to the
// output register; no new input is taken until that commit.
// Reset clears all stored averages, the frame count and the channel index and
// loads a window length of 64.
// If the receiver stalls, the finished result is held in the output register;
// the block still accepts and computes the next transaction, then waits with
// it until the output register is taken.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_running_mean (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,  // freq_in, amp_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,  // filtered_freq, filtered_amp
    output logic [mcrm_pkg::CH_OUT_W-1:0] m_tuser,  // channel
    output logic                          m_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mcrm_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import mcrm_pkg::*;

    dp_cmd_t             cmd;
    dp_stat_t            stat;
    logic [K_W-1:0]      window_len_reg;
    logic [DATA_W-1:0]   filtered_freq;
    logic [DATA_W-1:0]   filtered_amp;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= WINDOW_RESET;
        end else if (psel && penable && pwrite && paddr == REG_WINDOW_LEN) begin
            window_len_reg <= pwdata[K_W-1:0];
        end
    end

    assign prdata = (paddr == REG_WINDOW_LEN) ? {16'd0, window_len_reg} : 32'd0;

    mcrm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    mcrm_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .freq_in       (s_tdata[31:0]),
        .amp_in        (s_tdata[63:32]),
        .window_len    (window_len_reg),
        .filtered_freq (filtered_freq),
        .filtered_amp  (filtered_amp),
        .channel       (m_tuser),
        .last_channel  (m_tlast)
    );

    assign m_tdata = {filtered_amp, filtered_freq};

endmodule

`default_nettype wire

/* rtl/core/mcrm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module mcrm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output mcrm_pkg::dp_cmd_t  cmd,
    input  mcrm_pkg::dp_stat_t stat
);
    import mcrm_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/core/mcrm_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module mcrm_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  mcrm_pkg::dp_cmd_t                    cmd,
    output mcrm_pkg::dp_stat_t                   stat,
    input  logic signed [mcrm_pkg::DATA_W-1:0]   freq_in,
    input  logic signed [mcrm_pkg::DATA_W-1:0]   amp_in,
    input  logic        [mcrm_pkg::K_W-1:0]      window_len,
    output logic signed [mcrm_pkg::DATA_W-1:0]   filtered_freq,
    output logic signed [mcrm_pkg::DATA_W-1:0]   filtered_amp,
    output logic        [mcrm_pkg::CH_OUT_W-1:0] channel,
    output logic                                 last_channel
);
    import mcrm_pkg::*;

    logic signed [DATA_W-1:0] avg_freq_reg [NUM_CHANNELS];
    logic signed [DATA_W-1:0] avg_amp_reg  [NUM_CHANNELS];
    logic [CH_W-1:0]          ch_reg;
    logic [K_W-1:0]           frame_reg;

    logic signed [DATA_W-1:0] prev_f_reg;
    logic signed [DATA_W-1:0] prev_a_reg;
    logic [DATA_W-1:0]        quo_f_reg;
    logic [DATA_W-1:0]        quo_a_reg;
    logic [K_W:0]             rem_f_reg;
    logic [K_W:0]             rem_a_reg;
    logic                     neg_f_reg;
    logic                     neg_a_reg;
    logic [K_W-1:0]           k_reg;
    logic [CNT_W-1:0]         cnt_reg;

    logic signed [DATA_W-1:0] out_f_reg;
    logic signed [DATA_W-1:0] out_a_reg;
    logic [CH_OUT_W-1:0]      out_ch_reg;
    logic                     out_last_reg;

    logic [K_W-1:0]           cap;
    logic [K_W-1:0]           k_next;
    logic signed [DATA_W:0]   diff_f;
    logic signed [DATA_W:0]   diff_a;
    logic [DATA_W:0]          mag_f;
    logic [DATA_W:0]          mag_a;
    logic [K_W:0]             rem_f_sh;
    logic [K_W:0]             rem_a_sh;
    logic                     ge_f;
    logic                     ge_a;
    logic [DATA_W:0]          sq_f;
    logic [DATA_W:0]          sq_a;
    logic signed [DATA_W-1:0] new_f;
    logic signed [DATA_W-1:0] new_a;
    logic                     is_last;

    always_comb begin
        cap    = (window_len == '0) ? K_W'(1) : window_len;
        k_next = (frame_reg < cap) ? frame_reg : cap;

        diff_f = $signed({freq_in[DATA_W-1], freq_in})
               - $signed({avg_freq_reg[ch_reg][DATA_W-1], avg_freq_reg[ch_reg]});
        diff_a = $signed({amp_in[DATA_W-1], amp_in})
               - $signed({avg_amp_reg[ch_reg][DATA_W-1], avg_amp_reg[ch_reg]});
        mag_f  = diff_f[DATA_W] ? -diff_f : diff_f;
        mag_a  = diff_a[DATA_W] ? -diff_a : diff_a;

        rem_f_sh = {rem_f_reg[K_W-1:0], quo_f_reg[DATA_W-1]};
        rem_a_sh = {rem_a_reg[K_W-1:0], quo_a_reg[DATA_W-1]};
        ge_f     = rem_f_sh >= {1'b0, k_reg};
        ge_a     = rem_a_sh >= {1'b0, k_reg};

        sq_f  = neg_f_reg ? -{1'b0, quo_f_reg} : {1'b0, quo_f_reg};
        sq_a  = neg_a_reg ? -{1'b0, quo_a_reg} : {1'b0, quo_a_reg};
        new_f = (k_reg == '0) ? prev_f_reg : prev_f_reg + $signed(sq_f[DATA_W-1:0]);
        new_a = (k_reg == '0) ? prev_a_reg : prev_a_reg + $signed(sq_a[DATA_W-1:0]);

        is_last = (ch_reg == LAST_CH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                avg_freq_reg[i] <= '0;
                avg_amp_reg[i]  <= '0;
            end
            ch_reg    <= '0;
            frame_reg <= '0;
            cnt_reg   <= CNT_W'(DIV_STEPS);
        end else begin
            if (cmd.load) begin
                cnt_reg <= '0;
            end else if (cnt_reg != CNT_W'(DIV_STEPS)) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.commit) begin
                avg_freq_reg[ch_reg] <= new_f;
                avg_amp_reg[ch_reg]  <= new_a;
                if (is_last) begin
                    ch_reg <= '0;
                    if (frame_reg < cap) begin
                        frame_reg <= frame_reg + 1'b1;
                    end
                end else begin
                    ch_reg <= ch_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            prev_f_reg <= avg_freq_reg[ch_reg];
            prev_a_reg <= avg_amp_reg[ch_reg];
            quo_f_reg  <= mag_f[DATA_W-1:0];
            quo_a_reg  <= mag_a[DATA_W-1:0];
            rem_f_reg  <= '0;
            rem_a_reg  <= '0;
            neg_f_reg  <= diff_f[DATA_W];
            neg_a_reg  <= diff_a[DATA_W];
            k_reg      <= k_next;
        end else if (cnt_reg != CNT_W'(DIV_STEPS)) begin
            rem_f_reg <= ge_f ? rem_f_sh - {1'b0, k_reg} : rem_f_sh;
            rem_a_reg <= ge_a ? rem_a_sh - {1'b0, k_reg} : rem_a_sh;
            quo_f_reg <= {quo_f_reg[DATA_W-2:0], ge_f};
            quo_a_reg <= {quo_a_reg[DATA_W-2:0], ge_a};
        end
        if (cmd.commit) begin
            out_f_reg    <= new_f;
            out_a_reg    <= new_a;
            out_ch_reg   <= CH_OUT_W'(ch_reg);
            out_last_reg <= is_last;
        end
    end

    assign stat.div_done  = (cnt_reg == CNT_W'(DIV_STEPS));
    assign filtered_freq  = out_f_reg;
    assign filtered_amp   = out_a_reg;
    assign channel        = out_ch_reg;
    assign last_channel   = out_last_reg;

endmodule

`default_nettype wire

/* rtl/core/mcrm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mcrm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [63:0]                   m_tdata,
    input logic [mcrm_pkg::CH_OUT_W-1:0] m_tuser,
    input logic                          m_tlast
);
    import mcrm_pkg::*;

    `ASSERT_CLK(a_reset_clears_valid, aclk, !aresetn |=> !m_tvalid, "m_tvalid not cleared by reset")
    `ASSERT_CLK_RST(a_valid_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped while stalled")
    `ASSERT_CLK_RST(a_data_holds, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `ASSERT_CLK_RST(a_last_matches_channel, aclk, aresetn, m_tvalid |-> (m_tlast == (m_tuser == LAST_CH_TAG)), "m_tlast does not match the last channel")

endmodule

bind multichannel_running_mean mcrm_checker u_mcrm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
